FILE: src/sspt_pkg.sv
// shared constants and types for the screen segment pick test
// no dependencies; used by sspt_cfg and screen_segment_pick_test
package sspt_pkg;

  // default coordinate width of the input fields (signed, fixed point)
  localparam int COORD_WIDTH = 32;

  // configuration register width and register file layout
  localparam int CFG_WIDTH = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_SQ_W  = 2 * CFG_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_HIT_TOL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = CFG_IDX_W'(1);

  localparam logic [CFG_WIDTH-1:0] HIT_TOL_RESET = CFG_WIDTH'(524);
  localparam logic [CFG_WIDTH-1:0] MIN_LEN_RESET = CFG_WIDTH'(7);

  // squared thresholds handed from the register file to the datapath
  typedef struct packed {
    logic [CFG_SQ_W-1:0] tol2;
    logic [CFG_SQ_W-1:0] min2;
  } cfg_sq_t;

endpackage

FILE: src/sspt_cfg.sv
// configuration registers of the pick test, with registered squares
// depends on sspt_pkg
module sspt_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sspt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sspt_pkg::CFG_WIDTH-1:0]   cfg_data_i,
  output sspt_pkg::cfg_sq_t                cfg_sq_o
);

  logic [sspt_pkg::CFG_WIDTH-1:0] tol_q, tol_d;
  logic [sspt_pkg::CFG_WIDTH-1:0] minlen_q, minlen_d;
  logic [sspt_pkg::CFG_SQ_W-1:0]  tol2_q, min2_q;

  always_comb begin
    tol_d    = tol_q;
    minlen_d = minlen_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sspt_pkg::REG_HIT_TOL: tol_d    = cfg_data_i;
        sspt_pkg::REG_MIN_LEN: minlen_d = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= sspt_pkg::HIT_TOL_RESET;
      minlen_q <= sspt_pkg::MIN_LEN_RESET;
    end else begin
      tol_q    <= tol_d;
      minlen_q <= minlen_d;
    end
  end

  // squares are registered from the registers and follow them in the cycle after
  always_ff @(posedge clk_i) begin
    tol2_q <= sspt_pkg::CFG_SQ_W'(tol_q) * sspt_pkg::CFG_SQ_W'(tol_q);
    min2_q <= sspt_pkg::CFG_SQ_W'(minlen_q) * sspt_pkg::CFG_SQ_W'(minlen_q);
  end

  assign cfg_sq_o.tol2 = tol2_q;
  assign cfg_sq_o.min2 = min2_q;

endmodule

FILE: src/sspt_mul.sv
// two-stage unsigned multiplier split into four half-width partial products
// no package dependency; instantiated by the pick test top level
module sspt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic               clk_i,
  input  logic               en_pp_i,
  input  logic               en_sum_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  output logic [AW+BW-1:0]   p_o
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL-1:0]    a_lo;
  logic [AH-1:0]    a_hi;
  logic [BL-1:0]    b_lo;
  logic [BH-1:0]    b_hi;
  logic [AL+BL-1:0] ll_q;
  logic [AL+BH-1:0] lh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AH+BH-1:0] hh_q;
  logic [PW-1:0]    p_d, p_q;

  assign a_lo = a_i[AL-1:0];
  assign a_hi = a_i[AW-1:AL];
  assign b_lo = b_i[BL-1:0];
  assign b_hi = b_i[BW-1:BL];

  always_ff @(posedge clk_i) begin
    if (en_pp_i) begin
      ll_q <= (AL+BL)'(a_lo) * (AL+BL)'(b_lo);
      lh_q <= (AL+BH)'(a_lo) * (AL+BH)'(b_hi);
      hl_q <= (AH+BL)'(a_hi) * (AH+BL)'(b_lo);
      hh_q <= (AH+BH)'(a_hi) * (AH+BH)'(b_hi);
    end
  end

  assign p_d = PW'(ll_q)
             + (PW'(lh_q) << BL)
             + (PW'(hl_q) << AL)
             + (PW'(hh_q) << (AL + BL));

  always_ff @(posedge clk_i) begin
    if (en_sum_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

FILE: src/screen_segment_pick_test.sv
// screen segment pick test: ten register stages, one beat per cycle while unstalled
// path: the input beat is taken into stage 1; the result register is stage 10
// throughput: one segment per cycle; a stall at the output holds only the full
// stages behind it, so bubbles are squeezed out before the input stalls
// reset: all stage valid bits clear at once, hit_tolerance to 524, min_length to 7
// depends on sspt_pkg, sspt_cfg, sspt_mul
module screen_segment_pick_test #(
  parameter int COORD_WIDTH = sspt_pkg::COORD_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [sspt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sspt_pkg::CFG_WIDTH-1:0]       cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]        start_x_i,
  input  logic signed [COORD_WIDTH-1:0]        start_y_i,
  input  logic signed [COORD_WIDTH-1:0]        start_depth_i,
  input  logic signed [COORD_WIDTH-1:0]        end_x_i,
  input  logic signed [COORD_WIDTH-1:0]        end_y_i,
  input  logic signed [COORD_WIDTH-1:0]        end_depth_i,
  input  logic signed [COORD_WIDTH-1:0]        cursor_x_i,
  input  logic signed [COORD_WIDTH-1:0]        cursor_y_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 hit_o
);

  // all coordinates share one fixed-point scale, so every test below is
  // scale-free and the fraction width never enters the datapath
  localparam int DW   = COORD_WIDTH + 2;   // signed differences
  localparam int MW   = COORD_WIDTH + 1;   // their magnitudes
  localparam int PW   = 2 * MW;            // magnitude products
  localparam int SPW  = PW + 1;            // signed products
  localparam int SW   = SPW + 1;           // sums of two signed products
  localparam int LW   = PW + 1;            // squared length
  localparam int CW   = SW;                // cross product magnitude
  localparam int SQW  = sspt_pkg::CFG_SQ_W;
  localparam int X2W  = 2 * CW;            // cross squared
  localparam int BNW  = SQW + LW;          // tolerance bound
  localparam int CMPW = (X2W > BNW) ? X2W : BNW;
  localparam int NST  = 10;

  // ---------------------------------------------------------------------------
  // stage handshake: a stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  logic [NST:1] v_q;
  logic [NST:1] en;

  always_comb begin
    en[NST] = !v_q[NST] || !out_stall_i;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  sspt_pkg::cfg_sq_t cfg_sq;

  sspt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_sq_o   (cfg_sq)
  );

  // ---------------------------------------------------------------------------
  // stage 1: segment deltas and pointer offsets
  // the pointer is negated, so the offset from the start is -(pointer + start);
  // the sum is kept here and its sign flipped in stage 2
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] dx1_q, dy1_q, qax1_q, qay1_q;
  logic                 rej1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dx1_q  <= DW'(end_x_i) - DW'(start_x_i);
      dy1_q  <= DW'(end_y_i) - DW'(start_y_i);
      qax1_q <= DW'(cursor_x_i) + DW'(start_x_i);
      qay1_q <= DW'(cursor_y_i) + DW'(start_y_i);
      // an endpoint behind the viewer never hits
      rej1_q <= (start_depth_i > 0) || (end_depth_i > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: magnitudes and product signs
  // ---------------------------------------------------------------------------
  logic [MW-1:0] mdx2_q, mdy2_q, mpax2_q, mpay2_q;
  logic [3:0]    neg2_q, neg3_q, neg4_q;   // dx*pax, dy*pay, pax*dy, pay*dx
  logic          rej2_q, rej3_q, rej4_q;
  logic          sdx, sdy, spax, spay;

  assign sdx  = dx1_q[DW-1];
  assign sdy  = dy1_q[DW-1];
  assign spax = (qax1_q != '0) && !qax1_q[DW-1];
  assign spay = (qay1_q != '0) && !qay1_q[DW-1];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mdx2_q  <= dx1_q[DW-1]  ? MW'(-dx1_q)  : MW'(dx1_q);
      mdy2_q  <= dy1_q[DW-1]  ? MW'(-dy1_q)  : MW'(dy1_q);
      mpax2_q <= qax1_q[DW-1] ? MW'(-qax1_q) : MW'(qax1_q);
      mpay2_q <= qay1_q[DW-1] ? MW'(-qay1_q) : MW'(qay1_q);
      neg2_q  <= {spay ^ sdx, spax ^ sdy, sdy ^ spay, sdx ^ spax};
      rej2_q  <= rej1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 3-4: the six first-level products
  // the end-point dot test is folded in later: dot_end = len2 - dot_start
  // ---------------------------------------------------------------------------
  logic [PW-1:0] p_dxpax, p_dypay, p_dxdx, p_dydy, p_paxdy, p_paydx;

  sspt_mul #(.AW(MW), .BW(MW)) u_mul_dxpax (
    .clk_i (clk_i), .en_pp_i (en[3]), .en_sum_i (en[4]),
    .a_i (mdx2_q), .b_i (mpax2_q), .p_o (p_dxpax)
  );
  sspt_mul #(.AW(MW), .BW(MW)) u_mul_dypay (
    .clk_i (clk_i), .en_pp_i (en[3]), .en_sum_i (en[4]),
    .a_i (mdy2_q), .b_i (mpay2_q), .p_o (p_dypay)
  );
  sspt_mul #(.AW(MW), .BW(MW)) u_mul_dxdx (
    .clk_i (clk_i), .en_pp_i (en[3]), .en_sum_i (en[4]),
    .a_i (mdx2_q), .b_i (mdx2_q), .p_o (p_dxdx)
  );
  sspt_mul #(.AW(MW), .BW(MW)) u_mul_dydy (
    .clk_i (clk_i), .en_pp_i (en[3]), .en_sum_i (en[4]),
    .a_i (mdy2_q), .b_i (mdy2_q), .p_o (p_dydy)
  );
  sspt_mul #(.AW(MW), .BW(MW)) u_mul_paxdy (
    .clk_i (clk_i), .en_pp_i (en[3]), .en_sum_i (en[4]),
    .a_i (mpax2_q), .b_i (mdy2_q), .p_o (p_paxdy)
  );
  sspt_mul #(.AW(MW), .BW(MW)) u_mul_paydx (
    .clk_i (clk_i), .en_pp_i (en[3]), .en_sum_i (en[4]),
    .a_i (mpay2_q), .b_i (mdx2_q), .p_o (p_paydx)
  );

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      neg3_q <= neg2_q;
      rej3_q <= rej2_q;
    end
    if (en[4]) begin
      neg4_q <= neg3_q;
      rej4_q <= rej3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: restore product signs
  // ---------------------------------------------------------------------------
  logic signed [SPW-1:0] s_dxpax5_q, s_dypay5_q, s_paxdy5_q, s_paydx5_q;
  logic [PW-1:0]         sq_dx5_q, sq_dy5_q;
  logic                  rej5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s_dxpax5_q <= neg4_q[0] ? -$signed({1'b0, p_dxpax}) : $signed({1'b0, p_dxpax});
      s_dypay5_q <= neg4_q[1] ? -$signed({1'b0, p_dypay}) : $signed({1'b0, p_dypay});
      s_paxdy5_q <= neg4_q[2] ? -$signed({1'b0, p_paxdy}) : $signed({1'b0, p_paxdy});
      s_paydx5_q <= neg4_q[3] ? -$signed({1'b0, p_paydx}) : $signed({1'b0, p_paydx});
      sq_dx5_q   <= p_dxdx;
      sq_dy5_q   <= p_dydy;
      rej5_q     <= rej4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: start dot product, squared length, cross product
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] dot6_q, cross6_q;
  logic [LW-1:0]        len2_6_q;
  logic                 rej6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      dot6_q   <= SW'(s_dxpax5_q) + SW'(s_dypay5_q);
      cross6_q <= SW'(s_paxdy5_q) - SW'(s_paydx5_q);
      len2_6_q <= LW'(sq_dx5_q) + LW'(sq_dy5_q);
      rej6_q   <= rej5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: span and length tests, cross magnitude
  // before the start: dot < 0; beyond the end: dot > len2 (zero passes both)
  // ---------------------------------------------------------------------------
  logic [CW-1:0] xmag7_q;
  logic [LW-1:0] len2_7_q;
  logic          rej7_q, rej8_q, rej9_q;
  logic          before_start, beyond_end, too_short;

  assign before_start = dot6_q[SW-1];
  assign beyond_end   = dot6_q > $signed({1'b0, len2_6_q});
  assign too_short    = len2_6_q < LW'(cfg_sq.min2);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      xmag7_q  <= cross6_q[SW-1] ? CW'(-cross6_q) : CW'(cross6_q);
      len2_7_q <= len2_6_q;
      rej7_q   <= rej6_q || before_start || beyond_end || too_short;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 8-9: cross squared against tolerance squared times length squared
  // ---------------------------------------------------------------------------
  logic [X2W-1:0] cross2;
  logic [BNW-1:0] bound;

  sspt_mul #(.AW(CW), .BW(CW)) u_mul_cross2 (
    .clk_i (clk_i), .en_pp_i (en[8]), .en_sum_i (en[9]),
    .a_i (xmag7_q), .b_i (xmag7_q), .p_o (cross2)
  );
  sspt_mul #(.AW(SQW), .BW(LW)) u_mul_bound (
    .clk_i (clk_i), .en_pp_i (en[8]), .en_sum_i (en[9]),
    .a_i (cfg_sq.tol2), .b_i (len2_7_q), .p_o (bound)
  );

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      rej8_q <= rej7_q;
    end
    if (en[9]) begin
      rej9_q <= rej8_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: output register; equality with the bound still counts as a hit
  // ---------------------------------------------------------------------------
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (en[NST]) begin
      hit_q <= !rej9_q && !(CMPW'(cross2) > CMPW'(bound));
    end
  end

  assign hit_o = hit_q;

endmodule
